// ===== rtl/core/mmf_pkg.sv =====
// Shared types, constants and helpers for the min/max FIFO.
`timescale 1ns / 1ps

package mmf_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        T_IDLE,
        T_WAIT
    } top_state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_PUSH_CMP,
        M_POP_CAP
    } mono_state_t;

    // command from the queue control to one monotonic store
    typedef struct packed {
        logic   push;
        logic   pop;
        value_t value;
    } mono_cmd_t;

    // status back from one monotonic store
    typedef struct packed {
        logic   busy;
        logic   nonempty;
        value_t front;
    } mono_stat_t;

    // circular index: (head + off) mod CAPACITY, off never above CAPACITY
    function automatic idx_t slot(idx_t head, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

endpackage

// ===== rtl/core/min_max_fifo.sv =====
// Top level of the min/max FIFO: queue control, queue memory and result register.
`timescale 1ns / 1ps

// A FIFO of 16 signed 32-bit words that reports, after every push or pop, the
// oldest word held, the smallest and largest words held, the occupancy and a
// status (done, push dropped because full, pop ignored because empty). With
// the queue empty, front, min and max read as zero. The queue and two
// monotonic stores (min candidates, max candidates) each live in a 16-entry
// RAM with one write port and one registered read port. One operation is
// handled at a time. A rejected operation, or a push into an empty queue,
// needs no compare or fetch; a pop fetches a new head from RAM when one
// remains. A push into a non-empty queue waits for the slower of the two
// monotonic stores: the back of each store is read and compared one entry
// per cycle through its single read port, so a store that drops k entries
// needs k + 1 compares, or only k when it drops every entry it held. The
// result sits in an output register, so the next word is taken while an
// earlier result waits. No clearing pass runs after reset.

module min_max_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  mmf_pkg::value_t   value,
    output logic              out_valid,
    input  logic              out_stall,
    output mmf_pkg::value_t   front_value,
    output mmf_pkg::value_t   min_value,
    output mmf_pkg::value_t   max_value,
    output mmf_pkg::cnt_t     occupancy,
    output mmf_pkg::status_t  status
);
    import mmf_pkg::*;

    top_state_t state_reg, state_next;
    idx_t       head_reg, head_next;
    cnt_t       count_reg, count_next;
    value_t     front_reg, front_next;
    logic       front_pend_reg, front_pend_next;
    status_t    status_reg, status_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    value_t     out_front_reg, out_front_next;
    value_t     out_min_reg, out_min_next;
    value_t     out_max_reg, out_max_next;
    cnt_t       out_occ_reg, out_occ_next;
    status_t    out_status_reg, out_status_next;

    logic       ram_we;
    idx_t       ram_waddr;
    value_t     ram_wdata;
    idx_t       ram_raddr;
    value_t     ram_rdata;

    mono_cmd_t  min_cmd, max_cmd;
    mono_stat_t min_stat, max_stat;

    mmf_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_W)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mmf_mono u_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .keep_min (1'b1),
        .cmd      (min_cmd),
        .stat     (min_stat)
    );

    mmf_mono u_max (
        .clk      (clk),
        .rst_n    (rst_n),
        .keep_min (1'b0),
        .cmd      (max_cmd),
        .stat     (max_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        front_pend_next = front_pend_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_front_next  = out_front_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_occ_next    = out_occ_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot(head_reg, count_reg);
        ram_wdata       = value;
        ram_raddr       = slot(head_reg, CNT_W'(1));
        min_cmd         = '0;
        max_cmd         = '0;
        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = T_WAIT;
                    status_next = ST_DONE;
                    if (kind == OP_PUSH)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            if (count_reg == '0)
                            begin
                                front_next = value;
                            end
                            min_cmd.push  = 1'b1;
                            min_cmd.value = value;
                            max_cmd.push  = 1'b1;
                            max_cmd.value = value;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // old front leaves; fetch the next one if any
                            head_next       = slot(head_reg, CNT_W'(1));
                            count_next      = count_reg - CNT_W'(1);
                            front_pend_next = (count_reg > CNT_W'(1));
                            min_cmd.pop     = 1'b1;
                            min_cmd.value   = front_reg;
                            max_cmd.pop     = 1'b1;
                            max_cmd.value   = front_reg;
                        end
                    end
                end
            end
            T_WAIT:
            begin
                if (front_pend_reg)
                begin
                    front_next      = ram_rdata;
                    front_pend_next = 1'b0;
                end
                else if (!min_stat.busy && !max_stat.busy
                         && (!out_valid_reg || !out_stall))
                begin
                    out_valid_next  = 1'b1;
                    out_front_next  = (count_reg != '0) ? front_reg : '0;
                    out_min_next    = (count_reg != '0 && min_stat.nonempty)
                                      ? min_stat.front : '0;
                    out_max_next    = (count_reg != '0 && max_stat.nonempty)
                                      ? max_stat.front : '0;
                    out_occ_next    = count_reg;
                    out_status_next = status_reg;
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            front_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            front_pend_reg <= front_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        status_reg     <= status_next;
        out_front_reg  <= out_front_next;
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
        out_occ_reg    <= out_occ_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall    = (state_reg != T_IDLE);
    assign out_valid   = out_valid_reg;
    assign front_value = out_front_reg;
    assign min_value   = out_min_reg;
    assign max_value   = out_max_reg;
    assign occupancy   = out_occ_reg;
    assign status      = out_status_reg;

endmodule

// ===== rtl/core/mmf_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module mmf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mmf_mono.sv =====
// Monotonic store engine: keeps the running minimum or maximum candidates.
`timescale 1ns / 1ps

module mmf_mono (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               keep_min,
    input  mmf_pkg::mono_cmd_t cmd,
    output mmf_pkg::mono_stat_t stat
);
    import mmf_pkg::*;

    mono_state_t state_reg, state_next;
    idx_t        head_reg, head_next;
    cnt_t        count_reg, count_next;
    value_t      front_reg, front_next;
    value_t      val_reg, val_next;

    logic   ram_we;
    idx_t   ram_waddr;
    value_t ram_wdata;
    idx_t   ram_raddr;
    value_t ram_rdata;
    logic   drop;

    mmf_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back entry leaves the store if it breaks the ordering with the new value
    assign drop = keep_min ? (ram_rdata > val_reg) : (ram_rdata < val_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        front_next = front_reg;
        val_next   = val_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = val_reg;
        ram_raddr  = head_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (cmd.push)
                begin
                    val_next = cmd.value;
                    if (count_reg == '0)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = cmd.value;
                        count_next = CNT_W'(1);
                        front_next = cmd.value;
                    end
                    else
                    begin
                        ram_raddr  = slot(head_reg, count_reg - CNT_W'(1));
                        state_next = M_PUSH_CMP;
                    end
                end
                else if (cmd.pop)
                begin
                    if (count_reg != '0 && front_reg == cmd.value)
                    begin
                        head_next  = slot(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg > CNT_W'(1))
                        begin
                            ram_raddr  = slot(head_reg, CNT_W'(1));
                            state_next = M_POP_CAP;
                        end
                    end
                end
            end
            M_PUSH_CMP:
            begin
                if (drop)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        // store empties: new value becomes the only entry
                        ram_we     = 1'b1;
                        ram_waddr  = head_reg;
                        front_next = val_reg;
                        state_next = M_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        ram_raddr  = slot(head_reg, count_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot(head_reg, count_reg);
                    count_next = count_reg + CNT_W'(1);
                    state_next = M_IDLE;
                end
            end
            M_POP_CAP:
            begin
                front_next = ram_rdata;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        val_reg   <= val_next;
    end

    assign stat.busy     = (state_reg != M_IDLE);
    assign stat.nonempty = (count_reg != '0);
    assign stat.front    = front_reg;

endmodule

// ===== rtl/core/mmf_checker.sv =====
// Port-level checks on the min/max FIFO, bound to the top level.
`timescale 1ns / 1ps

module mmf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              kind,
    input mmf_pkg::value_t   value,
    input logic              out_valid,
    input logic              out_stall,
    input mmf_pkg::value_t   front_value,
    input mmf_pkg::value_t   min_value,
    input mmf_pkg::value_t   max_value,
    input mmf_pkg::cnt_t     occupancy,
    input mmf_pkg::status_t  status
);
    import mmf_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(front_value)
            && $stable(min_value) && $stable(max_value) && $stable(occupancy))
        else $error("result word changed while stalled");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && occupancy == '0 |->
            front_value == '0 && min_value == '0 && max_value == '0)
        else $error("empty queue reports non-zero values");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == CNT_W'(CAPACITY))
        else $error("push dropped while not full");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && occupancy != '0 |->
            min_value <= front_value && front_value <= max_value)
        else $error("front outside min/max bounds");

endmodule

bind min_max_fifo mmf_checker u_mmf_checker (.*);

// ===== test/tb_min_max_fifo.sv =====
// Self-checking testbench for the min/max FIFO: directed table, random operations, model.
`timescale 1ns / 1ps

module tb_min_max_fifo;

    import mmf_pkg::*;

    // per-cycle idle/stall chance in percent, and the run of operations with none of either
    localparam int IDLE_PCT      = 23;
    localparam int CALM_FIRST    = 300;
    localparam int CALM_LAST     = 420;
    localparam int RANDOM_OPS    = 650;
    localparam int DIRECTED_ROWS = 24;
    // generous margin over the longest operation, on top of stalls
    localparam int DRAIN_CYCLES  = 60;
    localparam int STUCK_LIMIT   = 2000;

    localparam value_t V_MAX = 32'h7FFF_FFFF;
    localparam value_t V_MIN = 32'h8000_0000;
    localparam value_t V_ZERO = '0;

    // what one result word carries
    typedef struct packed {
        value_t  front;
        value_t  lo;
        value_t  hi;
        cnt_t    occ;
        status_t st;
    } fifo_view_t;

    // one operation word, with an optional hand-written expectation
    typedef struct packed {
        op_t        op;
        value_t     data;
        logic       checked;
        fifo_view_t view;
    } fifo_op_t;

    // pushes that fill the queue in the directed part: duplicates, both extremes,
    // rises and falls so both candidate stores drop entries
    localparam value_t FILL_SET [16] = '{
        32'sd5, 32'sd5, -32'sd1, -32'sd1, 32'sd3, 32'sd0, V_MAX, V_MIN,
        32'sd2, 32'sd2, 32'sd9, -32'sd7, 32'sd4, 32'sd4, 32'sd1, 32'sd6
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    logic    kind = OP_PUSH;
    value_t  value = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    value_t  front_value;
    value_t  min_value;
    value_t  max_value;
    cnt_t    occupancy;
    status_t status;

    fifo_op_t   op_list[$];
    fifo_view_t views_due[$];
    int         ops_sent = 0;
    int         stuck = 0;
    bit         failed = 1'b0;

    // model state: the queue itself and the two monotonic candidate lists
    value_t held_q[$];
    value_t lo_cand[$];
    value_t hi_cand[$];

    min_max_fifo i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .front_value (front_value),
        .min_value   (min_value),
        .max_value   (max_value),
        .occupancy   (occupancy),
        .status      (status)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Applies one operation to the model and returns the word the block should give.
    function automatic fifo_view_t fifo_view_after(op_t op, value_t data);
        fifo_view_t v;
        value_t     gone;
        v.st = ST_DONE;
        if (op == OP_PUSH)
        begin
            if (held_q.size() >= CAPACITY)
            begin
                v.st = ST_FULL;
            end
            else
            begin
                held_q.insert(held_q.size(), data);
                // equal values stay, so duplicates survive a single pop
                while (lo_cand.size() > 0 && lo_cand[$] > data)
                begin
                    lo_cand.delete(lo_cand.size() - 1);
                end
                lo_cand.insert(lo_cand.size(), data);
                while (hi_cand.size() > 0 && hi_cand[$] < data)
                begin
                    hi_cand.delete(hi_cand.size() - 1);
                end
                hi_cand.insert(hi_cand.size(), data);
            end
        end
        else if (held_q.size() == 0)
        begin
            v.st = ST_EMPTY;
        end
        else
        begin
            gone = held_q[0];
            held_q.delete(0);
            if (lo_cand.size() > 0 && lo_cand[0] == gone)
            begin
                lo_cand.delete(0);
            end
            if (hi_cand.size() > 0 && hi_cand[0] == gone)
            begin
                hi_cand.delete(0);
            end
        end
        // an empty queue reads as all zero
        v.front = (held_q.size() > 0) ? held_q[0] : V_ZERO;
        v.lo    = (held_q.size() > 0 && lo_cand.size() > 0) ? lo_cand[0] : V_ZERO;
        v.hi    = (held_q.size() > 0 && hi_cand.size() > 0) ? hi_cand[0] : V_ZERO;
        v.occ   = cnt_t'(held_q.size());
        return v;
    endfunction

    function automatic fifo_op_t mk_op(op_t op, value_t data);
        fifo_op_t r;
        r = '0;
        r.op = op;
        r.data = data;
        return r;
    endfunction

    function automatic fifo_op_t mk_checked(op_t op, value_t data, value_t front,
                                            value_t lo, value_t hi, cnt_t occ,
                                            status_t st);
        fifo_op_t r;
        r = mk_op(op, data);
        r.checked = 1'b1;
        r.view.front = front;
        r.view.lo = lo;
        r.view.hi = hi;
        r.view.occ = occ;
        r.view.st = st;
        return r;
    endfunction

    // Directed table. Rows with an expectation are the ones obvious by hand:
    // pop on empty, the two extremes in and out, and a push into a full queue.
    function automatic fifo_op_t directed_row(int n);
        fifo_op_t r;
        case (n)
            0:  r = mk_checked(OP_POP, V_MAX, V_ZERO, V_ZERO, V_ZERO, cnt_t'(0),
                               ST_EMPTY);
            1:  r = mk_checked(OP_PUSH, V_MAX, V_MAX, V_MAX, V_MAX, cnt_t'(1),
                               ST_DONE);
            2:  r = mk_checked(OP_PUSH, V_MIN, V_MAX, V_MIN, V_MAX, cnt_t'(2),
                               ST_DONE);
            3:  r = mk_checked(OP_POP, V_ZERO, V_MIN, V_MIN, V_MIN, cnt_t'(1),
                               ST_DONE);
            4:  r = mk_checked(OP_POP, V_MIN, V_ZERO, V_ZERO, V_ZERO, cnt_t'(0),
                               ST_DONE);
            21: r = mk_checked(OP_PUSH, -32'sd12345, 32'sd5, V_MIN, V_MAX,
                               cnt_t'(16), ST_FULL);
            22: r = mk_op(OP_POP, V_ZERO);
            23: r = mk_op(OP_POP, V_ZERO);
            default: r = mk_op(OP_PUSH, FILL_SET[n-5]);
        endcase
        return r;
    endfunction

    // Mostly small values so duplicates and ties are common, some extremes, rest full range.
    function automatic value_t pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return value_t'(int'($urandom_range(0, 8)) - 4);
        end
        else if (sel == 5)
        begin
            case ($urandom_range(0, 3))
                0: return V_MAX;
                1: return V_MIN;
                2: return V_ZERO;
                default: return -32'sd1;
            endcase
        end
        return value_t'($urandom());
    endfunction

    // Drives operation words and records what each accepted word should give.
    always @(posedge clk)
    begin : drive_ops
        fifo_op_t   cur;
        fifo_op_t   nxt;
        fifo_view_t predicted;
        bit         calm;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                cur = op_list[ops_sent];
                // the model always runs so its state tracks hand-checked rows too
                predicted = fifo_view_after(cur.op, cur.data);
                views_due.insert(views_due.size(), cur.checked ? cur.view : predicted);
                ops_sent++;
            end
            calm = (ops_sent >= CALM_FIRST) && (ops_sent < CALM_LAST);
            // a stalled word is held as it is
            if (!(in_valid && in_stall))
            begin
                if (ops_sent < op_list.size() && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = op_list[ops_sent];
                    in_valid <= 1'b1;
                    kind <= nxt.op;
                    value <= nxt.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compares each accepted result word with the oldest one due.
    always @(posedge clk)
    begin : check_words
        fifo_view_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (views_due.size() == 0)
            begin
                $error("result word with none due: front_value %0d", front_value);
                failed = 1'b1;
            end
            else
            begin
                due = views_due[0];
                views_due.delete(0);
                if (front_value !== due.front)
                begin
                    $error("front_value: expected %0d, got %0d", due.front, front_value);
                    failed = 1'b1;
                end
                if (min_value !== due.lo)
                begin
                    $error("min_value: expected %0d, got %0d", due.lo, min_value);
                    failed = 1'b1;
                end
                if (max_value !== due.hi)
                begin
                    $error("max_value: expected %0d, got %0d", due.hi, max_value);
                    failed = 1'b1;
                end
                if (occupancy !== due.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", due.occ, occupancy);
                    failed = 1'b1;
                end
                if (status !== due.st)
                begin
                    $error("status: expected %0d, got %0d", due.st, status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck <= 0;
            end
            else
            begin
                stuck <= stuck + 1;
            end
            if (stuck >= STUCK_LIMIT)
            begin
                $display("min_max_fifo verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int push_pct;
        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            op_list.insert(op_list.size(), directed_row(n));
        end
        // alternate push-heavy and pop-heavy stretches so the queue swings
        // between empty and full, hitting both rejections along the way
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            push_pct = ((n / 48) % 2 == 0) ? 75 : 30;
            if ($urandom_range(0, 99) < push_pct)
            begin
                op_list.insert(op_list.size(), mk_op(OP_PUSH, pick_value()));
            end
            else
            begin
                op_list.insert(op_list.size(), mk_op(OP_POP, pick_value()));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (!(ops_sent == op_list.size() && views_due.size() == 0));
        // let any stray word show up before closing
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
        begin
            $display("min_max_fifo verification clean");
        end
        else
        begin
            $display("min_max_fifo verification failed");
        end
        $finish;
    end

endmodule

// ===== min_max_fifo.f =====
rtl/core/mmf_pkg.sv
rtl/core/mmf_ram.sv
rtl/core/mmf_mono.sv
rtl/core/min_max_fifo.sv
rtl/core/mmf_checker.sv
test/tb_min_max_fifo.sv
